// File: src/pic_pkg.sv
// Shared types, bus map and defaults for the platform interrupt controller.
package pic_pkg;

  localparam int NUM_SOURCES_DEF = 82;
  localparam int PRIO_BITS_DEF   = 3;
  localparam int LINE_COUNT      = 82;

  localparam logic [21:0] OFF_PENDING = 22'h001000;
  localparam logic [21:0] OFF_ENABLE  = 22'h002000;
  localparam logic [21:0] OFF_THRESH  = 22'h200000;
  localparam logic [21:0] OFF_CLAIM   = 22'h200004;

  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic en_wr;
    logic thr_wr;
    logic complete;
    logic sample;
    logic claim;
  } bits_op_t;

endpackage

// File: src/pic_ram.sv
// Generic single-port-write, registered-read RAM.
module pic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/pic_bits.sv
// Enable, pending and in-service bit vectors and the priority threshold.
module pic_bits #(
  parameter int NUM_SOURCES = pic_pkg::NUM_SOURCES_DEF,
  parameter int PRIO_BITS   = pic_pkg::PRIO_BITS_DEF,
  localparam int WORDS = (NUM_SOURCES + 31) / 32,
  localparam int VW    = WORDS * 32,
  localparam int VIW   = $clog2(VW),
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pic_pkg::bits_op_t    op,
  input  logic [31:0]          wdata,
  input  logic [WIW-1:0]       widx,
  input  logic [VW-1:0]        lines,
  input  logic [VIW-1:0]       claim_id,
  input  logic [VIW-1:0]       complete_id,
  output logic [VW-1:0]        enable_o,
  output logic [VW-1:0]        pending_o,
  output logic [VW-1:0]        elig_o,
  output logic [PRIO_BITS-1:0] thr_o
);

  localparam logic [VW-1:0] SRC_MASK = ({VW{1'b1}} >> (VW - NUM_SOURCES)) & ~VW'(1);

  logic [VW-1:0]        enable_r,  enable_nxt;
  logic [VW-1:0]        pending_r, pending_nxt;
  logic [VW-1:0]        insvc_r,   insvc_nxt;
  logic [PRIO_BITS-1:0] thr_r,     thr_nxt;

  always_comb begin
    enable_nxt  = enable_r;
    pending_nxt = pending_r;
    insvc_nxt   = insvc_r;
    thr_nxt     = thr_r;
    if (op.en_wr) begin
      enable_nxt[{widx, 5'b0} +: 32] = wdata & SRC_MASK[{widx, 5'b0} +: 32];
    end
    if (op.thr_wr) begin
      thr_nxt = wdata[PRIO_BITS-1:0];
    end
    if (op.complete) begin
      insvc_nxt[complete_id] = 1'b0;
    end
    if (op.sample) begin
      pending_nxt = pending_r | (lines & ~insvc_r & SRC_MASK);
    end
    if (op.claim) begin
      pending_nxt[claim_id] = 1'b0;
      insvc_nxt[claim_id]   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= '0;
      pending_r <= '0;
      insvc_r   <= '0;
      thr_r     <= '0;
    end else begin
      enable_r  <= enable_nxt;
      pending_r <= pending_nxt;
      insvc_r   <= insvc_nxt;
      thr_r     <= thr_nxt;
    end
  end

  assign enable_o  = enable_r;
  assign pending_o = pending_r;
  assign elig_o    = enable_r & pending_r;
  assign thr_o     = thr_r;

endmodule

// File: src/pic_scan.sv
// Priority scan engine: walks the priority RAM and tracks the best eligible source.
module pic_scan #(
  parameter int NUM_SOURCES = pic_pkg::NUM_SOURCES_DEF,
  parameter int PRIO_BITS   = pic_pkg::PRIO_BITS_DEF,
  localparam int IDW   = $clog2(NUM_SOURCES),
  localparam int WORDS = (NUM_SOURCES + 31) / 32,
  localparam int VW    = WORDS * 32,
  localparam int VIW   = $clog2(VW)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [VW-1:0]        elig,
  input  logic [PRIO_BITS-1:0] thr,
  input  logic [PRIO_BITS-1:0] ram_rdata,
  output logic                 active,
  output logic [IDW-1:0]       ram_raddr,
  output logic                 fin,
  output logic [IDW-1:0]       best_nxt
);

  localparam logic [IDW-1:0] LAST_ID = IDW'(NUM_SOURCES - 1);

  logic                 active_r, active_nxt;
  logic [IDW-1:0]       cnt_r,    cnt_nxt;
  logic                 vld_r,    vld_nxt;
  logic                 last_r,   last_nxt;
  logic [IDW-1:0]       id_d_r,   id_d_nxt;
  logic                 have_r,   have_nxt;
  logic [IDW-1:0]       best_r;
  logic [PRIO_BITS-1:0] bestp_r,  bestp_nxt;
  logic                 hit;

  assign hit = vld_r && elig[VIW'(id_d_r)] && (ram_rdata > thr) &&
               (!have_r || (ram_rdata > bestp_r));

  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    vld_nxt    = active_r;
    last_nxt   = active_r && (cnt_r == LAST_ID);
    id_d_nxt   = cnt_r;
    have_nxt   = have_r || hit;
    best_nxt   = hit ? id_d_r : best_r;
    bestp_nxt  = hit ? ram_rdata : bestp_r;
    if (active_r) begin
      if (cnt_r == LAST_ID) begin
        active_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + IDW'(1);
      end
    end
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = IDW'(1);
      have_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      vld_r    <= 1'b0;
      last_r   <= 1'b0;
      have_r   <= 1'b0;
      best_r   <= '0;
    end else begin
      active_r <= active_nxt;
      vld_r    <= vld_nxt;
      last_r   <= last_nxt;
      have_r   <= have_nxt;
      best_r   <= start ? '0 : best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    id_d_r  <= id_d_nxt;
    bestp_r <= bestp_nxt;
  end

  assign active    = active_r;
  assign ram_raddr = cnt_r;
  assign fin       = vld_r && last_r;

endmodule

// File: src/platform_interrupt_controller.sv
// Top level of the single-context platform interrupt controller.
//
// Usage: one input channel (in_*) carries items: a bus read, a bus write or a
// sample of the source lines, selected by in_tuser. Every item gives exactly
// one result item on the out_* channel: read data (zero for non-reads) and
// the interrupt request level as it stands after the item.
// Work: after acceptance, each item runs a priority scan, which reads the
// priority RAM one source per cycle (twice for a read of the claim register:
// once to pick the source, once to refresh the request level), and then
// gives its result. One item is worked on at a time; a new item is accepted
// while the previous result waits in the output register.
// Reset: rst_n clears all enable, pending and in-service bits and the
// threshold, then a clearing pass over all NUM_SOURCES entries zeroes the priority
// RAM; in_tready stays low during that pass.
// Stall: if out_tready is low, the finished result holds in the output
// register and the next item waits at the end of its work until it drains.
module platform_interrupt_controller #(
  parameter int NUM_SOURCES = pic_pkg::NUM_SOURCES_DEF,
  parameter int PRIO_BITS   = pic_pkg::PRIO_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // addr[21:0], wdata[53:22], lines_low[85:54], lines_mid[117:86], lines_high[135:118]
  input  logic [135:0] in_tdata,
  // kind[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // rdata[31:0], irq_request[32], zero pad [39:33]
  output logic [39:0]  out_tdata
);

  localparam int IDW   = $clog2(NUM_SOURCES);
  localparam int WORDS = (NUM_SOURCES + 31) / 32;
  localparam int VW    = WORDS * 32;
  localparam int VIW   = $clog2(VW);
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LC    = pic_pkg::LINE_COUNT;

  pic_pkg::state_t state_r, state_nxt;

  logic [1:0]   kind_r;
  logic [21:0]  addr_r;
  logic [31:0]  wdata_r;
  logic [LC-1:0] lines_r;

  logic [IDW-1:0] clr_cnt_r;
  logic           claim_ph_r;
  logic           prio_rd_r;
  logic [31:0]    rdata_r;
  logic           irq_r;
  logic           out_valid_r;
  logic [31:0]    out_rdata_r;
  logic           out_irq_r;

  logic                 in_acc;
  logic                 out_free;
  logic                 aligned;
  logic [9:0]           reg_sel;
  logic [9:0]           word_off;
  logic                 pid_ok;
  logic                 in_prio;
  logic                 in_pend;
  logic                 in_en;
  logic                 is_thr;
  logic                 is_claim;
  logic                 is_read;
  logic                 is_write;
  logic                 cpl_ok;
  logic [WIW-1:0]       widx;
  logic [31:0]          rd_direct;
  logic [VW-1:0]        lines_v;

  pic_pkg::bits_op_t    op;
  logic                 ram_we;
  logic [IDW-1:0]       ram_waddr;
  logic [PRIO_BITS-1:0] ram_wdata;
  logic [IDW-1:0]       ram_raddr;
  logic [PRIO_BITS-1:0] ram_rdata;
  logic                 scan_start;
  logic                 scan_active;
  logic [IDW-1:0]       scan_raddr;
  logic                 scan_fin;
  logic [IDW-1:0]       best_nxt;
  logic [VW-1:0]        enable_v;
  logic [VW-1:0]        pending_v;
  logic [VW-1:0]        elig_v;
  logic [PRIO_BITS-1:0] thr;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  assign aligned  = (addr_r[1:0] == 2'b00);
  assign reg_sel  = addr_r[21:12];
  assign word_off = addr_r[11:2];
  assign pid_ok   = (32'(word_off) < 32'(NUM_SOURCES));
  assign in_prio  = aligned && (reg_sel == 10'd0) && pid_ok;
  assign in_pend  = aligned && (reg_sel == pic_pkg::OFF_PENDING[21:12]) &&
                    (32'(word_off) < 32'(WORDS));
  assign in_en    = aligned && (reg_sel == pic_pkg::OFF_ENABLE[21:12]) &&
                    (32'(word_off) < 32'(WORDS));
  assign is_thr   = (addr_r == pic_pkg::OFF_THRESH);
  assign is_claim = (addr_r == pic_pkg::OFF_CLAIM);
  assign is_read  = (kind_r == pic_pkg::KIND_READ);
  assign is_write = (kind_r == pic_pkg::KIND_WRITE);
  assign cpl_ok   = (wdata_r != 32'd0) && (wdata_r < 32'(NUM_SOURCES));
  assign widx     = word_off[WIW-1:0];

  assign lines_v = VW'(lines_r);

  always_comb begin
    rd_direct = 32'd0;
    if (is_read) begin
      if (in_pend) begin
        rd_direct = pending_v[{widx, 5'b0} +: 32];
      end else if (in_en) begin
        rd_direct = enable_v[{widx, 5'b0} +: 32];
      end else if (is_thr) begin
        rd_direct = 32'(thr);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pic_pkg::ST_CLEAR: begin
        if (clr_cnt_r == IDW'(NUM_SOURCES - 1)) begin
          state_nxt = pic_pkg::ST_IDLE;
        end
      end
      pic_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = pic_pkg::ST_EXEC;
        end
      end
      pic_pkg::ST_EXEC: begin
        state_nxt = pic_pkg::ST_SCAN;
      end
      pic_pkg::ST_SCAN: begin
        if (scan_fin && !claim_ph_r) begin
          state_nxt = pic_pkg::ST_DONE;
        end
      end
      pic_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = pic_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pic_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = addr_r[IDW+1:2];
    ram_wdata  = wdata_r[PRIO_BITS-1:0];
    scan_start = 1'b0;
    op         = '0;
    case (state_r)
      pic_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      pic_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      pic_pkg::ST_EXEC: begin
        scan_start  = 1'b1;
        ram_we      = is_write && in_prio && (word_off != 10'd0);
        op.en_wr    = is_write && in_en;
        op.thr_wr   = is_write && is_thr;
        op.complete = is_write && is_claim && cpl_ok;
        op.sample   = (kind_r == pic_pkg::KIND_SAMPLE);
      end
      pic_pkg::ST_SCAN: begin
        if (scan_fin && claim_ph_r) begin
          scan_start = 1'b1;
          op.claim   = (best_nxt != '0);
        end
      end
      pic_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign ram_raddr = scan_active ? scan_raddr : addr_r[IDW+1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pic_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      claim_ph_r  <= 1'b0;
      prio_rd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pic_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + IDW'(1);
      end
      prio_rd_r <= (state_r == pic_pkg::ST_EXEC) && is_read && in_prio;
      if (state_r == pic_pkg::ST_EXEC) begin
        claim_ph_r <= is_read && is_claim;
      end else if (scan_fin) begin
        claim_ph_r <= 1'b0;
      end
      if (state_r == pic_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= in_tuser;
      addr_r  <= in_tdata[21:0];
      wdata_r <= in_tdata[53:22];
      lines_r <= in_tdata[135:54];
    end
    if (state_r == pic_pkg::ST_EXEC) begin
      rdata_r <= rd_direct;
    end else if (prio_rd_r) begin
      rdata_r <= 32'(ram_rdata);
    end else if (scan_fin && claim_ph_r) begin
      rdata_r <= 32'(best_nxt);
    end
    if (state_r == pic_pkg::ST_SCAN && scan_fin && !claim_ph_r) begin
      irq_r <= (best_nxt != '0);
    end
    if (state_r == pic_pkg::ST_DONE && out_free) begin
      out_rdata_r <= rdata_r;
      out_irq_r   <= irq_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_irq_r, out_rdata_r};

  pic_ram #(
    .WIDTH (PRIO_BITS),
    .DEPTH (NUM_SOURCES)
  ) u_prio_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pic_bits #(
    .NUM_SOURCES (NUM_SOURCES),
    .PRIO_BITS   (PRIO_BITS)
  ) u_bits (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (op),
    .wdata       (wdata_r),
    .widx        (widx),
    .lines       (lines_v),
    .claim_id    (VIW'(best_nxt)),
    .complete_id (wdata_r[VIW-1:0]),
    .enable_o    (enable_v),
    .pending_o   (pending_v),
    .elig_o      (elig_v),
    .thr_o       (thr)
  );

  pic_scan #(
    .NUM_SOURCES (NUM_SOURCES),
    .PRIO_BITS   (PRIO_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .elig      (elig_v),
    .thr       (thr),
    .ram_rdata (ram_rdata),
    .active    (scan_active),
    .ram_raddr (scan_raddr),
    .fin       (scan_fin),
    .best_nxt  (best_nxt)
  );

endmodule
